// ----- rtl/sc2ch_pkg.sv -----
// ----------------------------------------------------------------------------
// sc2ch_pkg: shared types and constants for the scancode translator
// Widths, scancode constants, item kinds and the controller command bundle.
// ----------------------------------------------------------------------------
package sc2ch_pkg;

   localparam int STACK_DEPTH = 512;
   localparam int KEY_SLOTS   = 128;
   localparam int NUM_MAPS    = 8;

   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int KEY_IW   = $clog2(KEY_SLOTS);
   localparam int KMAP_AW  = $clog2(NUM_MAPS * KEY_SLOTS);
   localparam int LEVEL_W  = 10;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // set-1 codes
   localparam logic [7:0] CODE_LIMIT     = 8'h57;
   localparam logic [7:0] CODE_CAPS      = 8'h3A;
   localparam logic [7:0] CODE_RSHIFT    = 8'h36;
   localparam logic [7:0] CODE_LSHIFT    = 8'h2A;
   localparam logic [7:0] CODE_RSHIFT_UP = 8'hB6;
   localparam logic [7:0] CODE_LSHIFT_UP = 8'hAA;
   localparam logic [7:0] CODE_NUM       = 8'h45;

   typedef enum logic [1:0] {
      FUNC_SCAN  = 2'd0,
      FUNC_MAP   = 2'd1,
      FUNC_POP   = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef struct packed {
      logic load;    // capture transaction, launch memory reads
      logic commit;  // apply item, load result register
   } cmd_type;

   // keymap address = map * KEY_SLOTS + index
   function automatic logic [KMAP_AW-1:0] km_addr(input logic [2:0] sel,
                                                  input logic [KEY_IW-1:0] idx);
      km_addr = KMAP_AW'(sel) * KMAP_AW'(KEY_SLOTS) + KMAP_AW'(idx);
   endfunction

endpackage

// ----- rtl/sc2ch_ctrl.sv -----
// ----------------------------------------------------------------------------
// sc2ch_ctrl: transaction sequencer
// Two-state machine: capture a request, then commit it once the result
// register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module sc2ch_ctrl
   import sc2ch_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_commit;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign can_commit = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (can_commit) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/sc2ch_dp.sv -----
// ----------------------------------------------------------------------------
// sc2ch_dp: translator datapath
// Modifier flags, keymap memory, character stack memory, stack count and
// the result register.
// ----------------------------------------------------------------------------
module sc2ch_dp
   import sc2ch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // captured item
   func_type   func_ff;
   logic [7:0] code_ff;
   logic [2:0] sel_ff;
   logic [6:0] slot_ff;
   logic [7:0] char_ff;

   // state
   logic             shift_ff, shift_in;
   logic             caps_ff, caps_in;
   logic             num_ff, num_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // memories
   logic [7:0] kmap_mem [NUM_MAPS*KEY_SLOTS];
   logic [7:0] stack_mem [STACK_DEPTH];
   logic [7:0] kmap_rd_ff;
   logic [7:0] stack_rd_ff;

   logic               km_we;
   logic [KMAP_AW-1:0] km_waddr;
   logic [KMAP_AW-1:0] km_raddr;
   logic               st_we;
   logic [STACK_AW-1:0] st_waddr;
   logic [STACK_AW-1:0] st_raddr;

   // result fields
   logic [7:0]         c_out;
   logic               c_valid, pushed, dropped, l_valid;
   logic [2:0]         l_bits;
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic is_char;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_tuser);
         code_ff <= req_tdata[7:0];
         sel_ff  <= req_tdata[10:8];
         slot_ff <= req_tdata[17:11];
         char_ff <= req_tdata[25:18];
      end
   end

   // reads launch with the transaction, using flags left by the previous item
   assign km_raddr = km_addr({num_ff, caps_ff, shift_ff}, KEY_IW'(req_tdata[7:0]));
   assign st_raddr = STACK_AW'(count_ff - CNT_W'(1));

   assign is_char = (code_ff < CODE_LIMIT) && ({1'b0, code_ff} < 9'(KEY_SLOTS));

   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      num_in   = num_ff;
      count_in = count_ff;
      c_out    = 8'd0;
      c_valid  = 1'b0;
      pushed   = 1'b0;
      dropped  = 1'b0;
      l_valid  = 1'b0;
      km_we    = 1'b0;
      st_we    = 1'b0;
      km_waddr = km_addr(sel_ff, KEY_IW'(slot_ff));
      st_waddr = STACK_AW'(count_ff);
      case (func_ff)
         FUNC_SCAN: begin
            if (code_ff == CODE_RSHIFT_UP || code_ff == CODE_LSHIFT_UP) begin
               shift_in = 1'b0;
            end else if (code_ff == CODE_RSHIFT || code_ff == CODE_LSHIFT) begin
               shift_in = 1'b1;
            end else if (code_ff == CODE_CAPS) begin
               caps_in = !caps_ff;
               l_valid = 1'b1;
            end else if (code_ff == CODE_NUM) begin
               num_in  = !num_ff;
               l_valid = 1'b1;
            end else if (is_char) begin
               if (count_ff < CNT_W'(STACK_DEPTH)) begin
                  st_we    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  pushed   = 1'b1;
               end else begin
                  dropped = 1'b1;
               end
            end
         end
         FUNC_MAP: begin
            km_we = ({2'b00, slot_ff} < 9'(KEY_SLOTS));
         end
         FUNC_POP: begin
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
               c_out    = stack_rd_ff;
               c_valid  = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: count_in = count_ff;
      endcase
      l_bits = l_valid ? {caps_in, num_in, 1'b1} : 3'b000;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && km_we) begin
         kmap_mem[km_waddr] <= char_ff;
      end
      if (cmd.load) begin
         kmap_rd_ff <= kmap_mem[km_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && st_we) begin
         stack_mem[st_waddr] <= kmap_rd_ff;
      end
      if (cmd.load) begin
         stack_rd_ff <= stack_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
         num_ff   <= 1'b0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
         num_ff   <= num_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= RSP_DATA_W'({LEVEL_W'(count_in), l_bits, l_valid,
                                dropped, pushed, c_valid, c_out});
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ----- rtl/scancode_to_char_with_modifiers.sv -----
// ----------------------------------------------------------------------------
// scancode_to_char_with_modifiers: set-1 scancode translator
// Tracks shift, caps-lock and num-lock, maps scancodes through eight
// keymaps and keeps translated characters on a LIFO.
// ----------------------------------------------------------------------------
// Sequencing: a request transaction captures the item and starts the reads
//    in IDLE; the result register loads at the commit in EXEC. The keymap and
//    stack memories have registered reads, so each item has a read step and a
//    commit step; no new request is taken until the item has committed.
// A waiting result does not block the next request; a commit waits for it.
// Reset (synchronous): flags and stack level clear; keymap and stack
//    contents are left as they are and no clearing pass is run.
// ----------------------------------------------------------------------------
module scancode_to_char_with_modifiers
   import sc2ch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] scan_code, [10:8] map_select, [17:11] map_slot, [25:18] map_char
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func (0 scancode, 1 keymap write, 2 pop, 3 clear)
   input  logic [1:0]            req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] char_out, [8] char_valid, [9] char_pushed, [10] push_dropped,
   // [11] led_valid, [14:12] led_bits, [24:15] stack_level
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type cmd;

   // controller: owns handshakes and sequencing
   sc2ch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: flags, memories, stack count, result register
   sc2ch_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- rtl/sc2ch_check.sv -----
// ----------------------------------------------------------------------------
// sc2ch_check: port-level checks for the scancode translator
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module sc2ch_check
   import sc2ch_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear channels");

   // one item in flight: busy in the cycle after a transaction
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_push_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[10]) && !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("conflicting push/pop flags");

   a_led_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11] ? rsp_tdata[12] : (rsp_tdata[14:12] == 3'b000)))
      else $error("bad LED byte");

endmodule

bind scancode_to_char_with_modifiers sc2ch_check u_check (.*);
